// ----- src/assert_macros.svh -----
// Shared assertion macros, clocked on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define EFA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("extension field alu check failed");

// Check that a stalled output beat keeps its payload.
`define EFA_ASSERT_STABLE(lbl, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        out_valid && out_stall |=> $stable(sig)) \
        else $error("output payload changed under stall");

`endif

// ----- src/efa_pkg.sv -----
package efa_pkg;

    localparam int NCOEF      = 4;
    localparam int COEF_BITS  = 16;
    localparam int NPROD      = 2 * NCOEF - 1;
    localparam int LANES      = 2 * NCOEF;
    localparam int XW         = 2 * COEF_BITS + 3;
    localparam int CW         = XW + COEF_BITS;
    localparam int MW         = 2 * COEF_BITS;
    localparam int RED_STEPS  = 4;
    localparam int RED_STAGES = (XW + 1 + RED_STEPS - 1) / RED_STEPS;
    localparam int RED_TOP    = RED_STAGES * RED_STEPS - 1;
    localparam int PIW        = $clog2(NPROD);
    localparam int CFG_IW     = 3;

    typedef logic [COEF_BITS-1:0] coef_t;
    typedef logic [COEF_BITS:0]   sum17_t;
    typedef logic [XW-1:0]        lane_t;
    typedef logic [CW-1:0]        cmp_t;
    typedef logic [MW-1:0]        mprod_t;
    typedef logic [PIW-1:0]       pidx_t;
    typedef logic [CFG_IW-1:0]    cfg_idx_t;
    typedef lane_t [LANES-1:0]    lanes_t;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_NEG = 2'd2,
        CMD_MUL = 2'd3
    } cmd_t;

    localparam cfg_idx_t REG_PRIME = 3'd0;
    localparam cfg_idx_t REG_POLY0 = 3'd1;
    localparam cfg_idx_t REG_POLY1 = 3'd2;
    localparam cfg_idx_t REG_POLY2 = 3'd3;
    localparam cfg_idx_t REG_POLY3 = 3'd4;

    typedef struct packed {
        cmd_t  cmd;
        coef_t lhs_coef0;
        coef_t lhs_coef1;
        coef_t lhs_coef2;
        coef_t lhs_coef3;
        coef_t rhs_coef0;
        coef_t rhs_coef1;
        coef_t rhs_coef2;
        coef_t rhs_coef3;
    } in_item_t;

    typedef struct packed {
        coef_t res_coef0;
        coef_t res_coef1;
        coef_t res_coef2;
        coef_t res_coef3;
        logic  operands_equal;
        logic  left_is_zero;
    } out_item_t;

    // Sideband that rides along the pipeline with each beat
    typedef struct packed {
        cmd_t                   cmd;
        logic                   eq;
        logic                   lz;
        coef_t [NCOEF-1:0]      lin;
        coef_t [NPROD-1:0]      prod;
    } side_t;

endpackage

// ----- src/extension_field_alu.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  efa_pkg::in_item_t
// out       output     out_valid/out_stall  efa_pkg::out_item_t
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One beat per cycle sustained while in_stall is low; results leave through the output register.
// Latency comes mostly from the restoring mod-p reducers, 4 subtract steps a stage over
// 36 shift positions, used once for the operands, once for the product and once
// per polynomial fold. Reset clears valid bits and sets p to 2, poly coefs to 0.
// An output register plus one skid entry take results; in_stall rises only when
// the skid entry is full, and then the whole pipeline holds.
module extension_field_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  efa_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output efa_pkg::out_item_t  out_item,
    input  logic                cfg_we,
    input  efa_pkg::cfg_idx_t   cfg_index,
    input  efa_pkg::coef_t      cfg_data
);

    efa_pkg::coef_t                    prime_reg;
    efa_pkg::coef_t [efa_pkg::NCOEF-1:0] poly_reg;
    efa_pkg::coef_t                    p_eff;
    logic                              en;
    logic                              accept;
    efa_pkg::side_t                    e_side;
    efa_pkg::lanes_t                   e_x;
    logic                              r1_v;
    efa_pkg::side_t                    r1_side;
    efa_pkg::lanes_t                   r1_x;
    logic                              m_v;
    efa_pkg::side_t                    m_side;
    efa_pkg::lanes_t                   m_x;
    logic                              r2_v;
    efa_pkg::side_t                    r2_side;
    efa_pkg::lanes_t                   r2_x;
    logic                              rv    [efa_pkg::NCOEF];
    efa_pkg::side_t                    rside [efa_pkg::NCOEF];
    efa_pkg::side_t                    f_side;
    efa_pkg::out_item_t                f_item;
    logic                              f_v;
    logic                              out_valid_reg;
    efa_pkg::out_item_t                out_reg;
    logic                              skid_valid_reg;
    efa_pkg::out_item_t                skid_reg;
    logic                              out_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= efa_pkg::coef_t'(2);
            poly_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                efa_pkg::REG_PRIME: prime_reg   <= cfg_data;
                efa_pkg::REG_POLY0: poly_reg[0] <= cfg_data;
                efa_pkg::REG_POLY1: poly_reg[1] <= cfg_data;
                efa_pkg::REG_POLY2: poly_reg[2] <= cfg_data;
                efa_pkg::REG_POLY3: poly_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign p_eff = (prime_reg < efa_pkg::coef_t'(2)) ? efa_pkg::coef_t'(2) : prime_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;

    // Entry: flags on raw values, operands into reducer lanes
    always_comb
    begin
        e_side      = '0;
        e_side.cmd  = in_item.cmd;
        e_side.eq   = (in_item.lhs_coef0 == in_item.rhs_coef0)
                   && (in_item.lhs_coef1 == in_item.rhs_coef1)
                   && (in_item.lhs_coef2 == in_item.rhs_coef2)
                   && (in_item.lhs_coef3 == in_item.rhs_coef3);
        e_side.lz   = (in_item.lhs_coef0 == '0) && (in_item.lhs_coef1 == '0)
                   && (in_item.lhs_coef2 == '0) && (in_item.lhs_coef3 == '0);
        e_x[0] = efa_pkg::lane_t'(in_item.lhs_coef0);
        e_x[1] = efa_pkg::lane_t'(in_item.lhs_coef1);
        e_x[2] = efa_pkg::lane_t'(in_item.lhs_coef2);
        e_x[3] = efa_pkg::lane_t'(in_item.lhs_coef3);
        e_x[4] = efa_pkg::lane_t'(in_item.rhs_coef0);
        e_x[5] = efa_pkg::lane_t'(in_item.rhs_coef1);
        e_x[6] = efa_pkg::lane_t'(in_item.rhs_coef2);
        e_x[7] = efa_pkg::lane_t'(in_item.rhs_coef3);
    end

    efa_reduce u_red_in (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .v_i    (accept),
        .side_i (e_side),
        .x_i    (e_x),
        .p      (p_eff),
        .v_o    (r1_v),
        .side_o (r1_side),
        .x_o    (r1_x)
    );

    efa_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .v_i    (r1_v),
        .side_i (r1_side),
        .x_i    (r1_x),
        .p      (p_eff),
        .v_o    (m_v),
        .side_o (m_side),
        .x_o    (m_x)
    );

    efa_reduce u_red_prod (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .v_i    (m_v),
        .side_i (m_side),
        .x_i    (m_x),
        .p      (p_eff),
        .v_o    (r2_v),
        .side_o (r2_side),
        .x_o    (r2_x)
    );

    // Load reduced product coefficients into the sideband
    always_comb
    begin
        rside[0] = r2_side;
        for (int k = 0; k < efa_pkg::NPROD; k++)
        begin
            rside[0].prod[k] = r2_x[k][efa_pkg::COEF_BITS-1:0];
        end
    end

    assign rv[0] = r2_v;

    // Fold degrees from the top down
    for (genvar r = 0; r < efa_pkg::NCOEF - 1; r++)
    begin : g_round
        efa_round u_round (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .v_i    (rv[r]),
            .side_i (rside[r]),
            .idx    (efa_pkg::pidx_t'(efa_pkg::NPROD - 1 - r)),
            .c      (poly_reg),
            .p      (p_eff),
            .v_o    (rv[r+1]),
            .side_o (rside[r+1])
        );
    end

    assign f_side = rside[efa_pkg::NCOEF-1];
    assign f_v    = rv[efa_pkg::NCOEF-1];

    // Pick product or linear result
    always_comb
    begin
        if (f_side.cmd == efa_pkg::CMD_MUL)
        begin
            f_item.res_coef0 = f_side.prod[0];
            f_item.res_coef1 = f_side.prod[1];
            f_item.res_coef2 = f_side.prod[2];
            f_item.res_coef3 = f_side.prod[3];
        end
        else
        begin
            f_item.res_coef0 = f_side.lin[0];
            f_item.res_coef1 = f_side.lin[1];
            f_item.res_coef2 = f_side.lin[2];
            f_item.res_coef3 = f_side.lin[3];
        end
        f_item.operands_equal = f_side.eq;
        f_item.left_is_zero   = f_side.lz;
    end

    assign out_take = out_valid_reg && !out_stall;

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg <= f_v;
        end
        else if (f_v)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_reg <= f_item;
        end
        else
        begin
            skid_reg <= f_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ----- src/efa_reduce.sv -----
module efa_reduce (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            v_i,
    input  efa_pkg::side_t  side_i,
    input  efa_pkg::lanes_t x_i,
    input  efa_pkg::coef_t  p,
    output logic            v_o,
    output efa_pkg::side_t  side_o,
    output efa_pkg::lanes_t x_o
);

    logic            v_reg    [efa_pkg::RED_STAGES];
    efa_pkg::side_t  side_reg [efa_pkg::RED_STAGES];
    efa_pkg::lanes_t x_reg    [efa_pkg::RED_STAGES];

    for (genvar s = 0; s < efa_pkg::RED_STAGES; s++)
    begin : g_stage
        logic            v_cur;
        efa_pkg::side_t  side_cur;
        efa_pkg::lanes_t x_cur;
        efa_pkg::lanes_t x_next;

        if (s == 0)
        begin : g_first
            assign v_cur    = v_i;
            assign side_cur = side_i;
            assign x_cur    = x_i;
        end
        else
        begin : g_rest
            assign v_cur    = v_reg[s-1];
            assign side_cur = side_reg[s-1];
            assign x_cur    = x_reg[s-1];
        end

        // Restoring reduction: subtract p shifted, high shift first
        always_comb
        begin
            efa_pkg::cmp_t sh;
            x_next = x_cur;
            for (int l = 0; l < efa_pkg::LANES; l++)
            begin
                for (int t = 0; t < efa_pkg::RED_STEPS; t++)
                begin
                    sh = efa_pkg::cmp_t'(p) << (efa_pkg::RED_TOP - (s * efa_pkg::RED_STEPS + t));
                    if (efa_pkg::cmp_t'(x_next[l]) >= sh)
                    begin
                        x_next[l] = x_next[l] - sh[efa_pkg::XW-1:0];
                    end
                end
            end
        end

        // Advance valid bits
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_cur;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= x_next;
                side_reg[s] <= side_cur;
            end
        end
    end

    assign v_o    = v_reg[efa_pkg::RED_STAGES-1];
    assign side_o = side_reg[efa_pkg::RED_STAGES-1];
    assign x_o    = x_reg[efa_pkg::RED_STAGES-1];

endmodule

// ----- src/efa_mul.sv -----
module efa_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            v_i,
    input  efa_pkg::side_t  side_i,
    input  efa_pkg::lanes_t x_i,
    input  efa_pkg::coef_t  p,
    output logic            v_o,
    output efa_pkg::side_t  side_o,
    output efa_pkg::lanes_t x_o
);

    logic             v1_reg;
    efa_pkg::side_t   side1_reg;
    efa_pkg::side_t   side1_next;
    efa_pkg::mprod_t  prod_reg  [efa_pkg::NCOEF][efa_pkg::NCOEF];
    efa_pkg::mprod_t  prod_next [efa_pkg::NCOEF][efa_pkg::NCOEF];
    logic             v2_reg;
    efa_pkg::side_t   side2_reg;
    efa_pkg::lanes_t  x2_reg;
    efa_pkg::lanes_t  x2_next;

    // Linear ops and partial products
    always_comb
    begin
        efa_pkg::coef_t  a_c;
        efa_pkg::coef_t  b_c;
        efa_pkg::sum17_t s17;
        side1_next = side_i;
        for (int i = 0; i < efa_pkg::NCOEF; i++)
        begin
            a_c = x_i[i][efa_pkg::COEF_BITS-1:0];
            b_c = x_i[efa_pkg::NCOEF+i][efa_pkg::COEF_BITS-1:0];
            case (side_i.cmd)
                efa_pkg::CMD_ADD: s17 = {1'b0, a_c} + {1'b0, b_c};
                efa_pkg::CMD_SUB: s17 = {1'b0, a_c} + {1'b0, p} - {1'b0, b_c};
                efa_pkg::CMD_NEG: s17 = {1'b0, p} - {1'b0, a_c};
                default:          s17 = '0;
            endcase
            if (s17 >= {1'b0, p})
            begin
                s17 = s17 - {1'b0, p};
            end
            side1_next.lin[i] = s17[efa_pkg::COEF_BITS-1:0];
            for (int j = 0; j < efa_pkg::NCOEF; j++)
            begin
                prod_next[i][j] = efa_pkg::mprod_t'(a_c)
                                * efa_pkg::mprod_t'(x_i[efa_pkg::NCOEF+j][efa_pkg::COEF_BITS-1:0]);
            end
        end
    end

    // Gather partial products by degree
    always_comb
    begin
        x2_next = '0;
        for (int i = 0; i < efa_pkg::NCOEF; i++)
        begin
            for (int j = 0; j < efa_pkg::NCOEF; j++)
            begin
                x2_next[i+j] = x2_next[i+j] + efa_pkg::lane_t'(prod_reg[i][j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_i;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            prod_reg  <= prod_next;
            side2_reg <= side1_reg;
            x2_reg    <= x2_next;
        end
    end

    assign v_o    = v2_reg;
    assign side_o = side2_reg;
    assign x_o    = x2_reg;

endmodule

// ----- src/efa_round.sv -----
module efa_round (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            v_i,
    input  efa_pkg::side_t                  side_i,
    input  efa_pkg::pidx_t                  idx,
    input  efa_pkg::coef_t [efa_pkg::NCOEF-1:0] c,
    input  efa_pkg::coef_t                  p,
    output logic                            v_o,
    output efa_pkg::side_t                  side_o
);

    logic             v1_reg;
    efa_pkg::side_t   side1_reg;
    efa_pkg::mprod_t  m_reg [efa_pkg::NCOEF];
    logic             v2_reg;
    efa_pkg::side_t   side2_reg;
    efa_pkg::lanes_t  x2_reg;
    efa_pkg::lanes_t  x2_next;
    logic             red_v;
    efa_pkg::side_t   red_side;
    efa_pkg::lanes_t  red_x;

    // Fold top coefficient: prod[k] + p*2^16 - t*c_j, never negative
    always_comb
    begin
        efa_pkg::pidx_t pos;
        x2_next = '0;
        for (int j = 0; j < efa_pkg::NCOEF; j++)
        begin
            pos = idx - efa_pkg::pidx_t'(efa_pkg::NCOEF) + efa_pkg::pidx_t'(j);
            x2_next[j] = efa_pkg::lane_t'(side1_reg.prod[pos])
                       + (efa_pkg::lane_t'(p) << efa_pkg::COEF_BITS)
                       - efa_pkg::lane_t'(m_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_i;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_i;
            for (int j = 0; j < efa_pkg::NCOEF; j++)
            begin
                m_reg[j] <= efa_pkg::mprod_t'(side_i.prod[idx]) * efa_pkg::mprod_t'(c[j]);
            end
            side2_reg <= side1_reg;
            x2_reg    <= x2_next;
        end
    end

    efa_reduce u_reduce (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .v_i    (v2_reg),
        .side_i (side2_reg),
        .x_i    (x2_reg),
        .p      (p),
        .v_o    (red_v),
        .side_o (red_side),
        .x_o    (red_x)
    );

    // Write reduced coefficients back, drop the folded one
    always_comb
    begin
        efa_pkg::pidx_t pos;
        side_o = red_side;
        side_o.prod[idx] = '0;
        for (int j = 0; j < efa_pkg::NCOEF; j++)
        begin
            pos = idx - efa_pkg::pidx_t'(efa_pkg::NCOEF) + efa_pkg::pidx_t'(j);
            side_o.prod[pos] = red_x[j][efa_pkg::COEF_BITS-1:0];
        end
    end

    assign v_o = red_v;

endmodule

// ----- src/efa_checker.sv -----
`include "assert_macros.svh"

module efa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input efa_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input efa_pkg::out_item_t out_item
);

    logic zero_ops;
    logic res_zero;

    // Both operands zero, and every result coefficient zero
    assign zero_ops = out_item.left_is_zero && out_item.operands_equal;
    assign res_zero = (out_item.res_coef0 == '0) && (out_item.res_coef1 == '0)
                   && (out_item.res_coef2 == '0) && (out_item.res_coef3 == '0);

    // Hold a stalled input beat
    `EFA_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_item))

    // Hold a stalled output beat
    `EFA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
    `EFA_ASSERT_STABLE(a_out_stable, out_item)

    // Zero operands give a zero result under every command
    `EFA_ASSERT(a_zero_result, out_valid && zero_ops |-> res_zero)

    // Input stall only follows a stalled output
    `EFA_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall))

endmodule

bind extension_field_alu efa_checker u_efa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
